@@ hw/rtl/bsp_point_location_walk_macros.svh @@
// Assertion macros for the partition walk checker.
`ifndef BSP_POINT_LOCATION_WALK_MACROS_SVH
`define BSP_POINT_LOCATION_WALK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define BSP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bsp_pkg.sv @@
// Shared types and constants for the partition point location walk.
`timescale 1ns / 1ps

package bsp_pkg;

  localparam int DEF_MAX_NODES  = 4096;
  localparam int DEF_MAX_LEAVES = 8192;
  localparam int COORD_W        = 32;
  localparam int CHILD_W        = 13;
  localparam int SLOT_W         = 12;
  localparam int COUNT_W        = 13;
  localparam int LEAF_W         = 13;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // One stored partition node
  typedef struct packed {
    logic               back_is_leaf;
    logic [CHILD_W-1:0] back_child;
    logic               front_is_leaf;
    logic [CHILD_W-1:0] front_child;
    logic [COORD_W-1:0] dir_y;
    logic [COORD_W-1:0] dir_x;
    logic [COORD_W-1:0] org_y;
    logic [COORD_W-1:0] org_x;
  } node_t;

  // Request to the side test unit
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [COORD_W-1:0] dir_x;
    logic [COORD_W-1:0] dir_y;
  } side_req_t;

  // Answer of the side test unit
  typedef struct packed {
    logic done;
    logic side;
  } side_res_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_FETCH,
    W_START,
    W_WAIT,
    W_FINISH
  } walk_state_t;

  typedef enum logic [1:0] {
    SD_IDLE,
    SD_MUL_A,
    SD_MUL_B,
    SD_CMP
  } side_state_t;

endpackage

@@ hw/rtl/bsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/bsp_side.sv @@
// Side test of a point against one partition line, with sequenced multiplies.
`timescale 1ns / 1ps

module bsp_side (
  input  logic                  clk,
  input  logic                  rst,
  input  bsp_pkg::side_req_t    req,
  output bsp_pkg::side_res_t    res
);

  localparam int W = bsp_pkg::COORD_W;
  localparam int HW = W / 2;
  localparam int PW = W + HW;

  bsp_pkg::side_state_t state, state_next;

  logic         done_next;
  logic         side_next;
  logic         load_rel;
  logic [W-1:0] rx, ry;
  logic [W-1:0] prod_a, prod_b;
  logic [W-1:0] rx_c, ry_c;
  logic         dx_zero, dy_zero, sign_mix;
  logic signed [PW-1:0] mul_a, mul_b;

  // Relative position and quick decisions
  assign rx_c     = req.px - req.org_x;
  assign ry_c     = req.py - req.org_y;
  assign dx_zero  = (req.dir_x == '0);
  assign dy_zero  = (req.dir_y == '0);
  assign sign_mix = req.dir_y[W-1] ^ req.dir_x[W-1] ^ rx_c[W-1] ^ ry_c[W-1];

  // Products with the integer part of each direction
  assign mul_a = PW'($signed(ry)) * PW'($signed(req.dir_x[W-1:HW]));
  assign mul_b = PW'($signed(req.dir_y[W-1:HW])) * PW'($signed(rx));

  // Next state and outputs
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    side_next  = res.side;
    load_rel   = 1'b0;
    case (state)
      bsp_pkg::SD_IDLE: begin
        if (req.start) begin
          if (dx_zero) begin
            done_next = 1'b1;
            side_next = ($signed(req.px) <= $signed(req.org_x)) ?
                        ($signed(req.dir_y) > 0) : ($signed(req.dir_y) < 0);
          end else if (dy_zero) begin
            done_next = 1'b1;
            side_next = ($signed(req.py) <= $signed(req.org_y)) ?
                        ($signed(req.dir_x) < 0) : ($signed(req.dir_x) > 0);
          end else if (sign_mix) begin
            done_next = 1'b1;
            side_next = req.dir_y[W-1] ^ rx_c[W-1];
          end else begin
            load_rel   = 1'b1;
            state_next = bsp_pkg::SD_MUL_A;
          end
        end
      end
      bsp_pkg::SD_MUL_A: state_next = bsp_pkg::SD_MUL_B;
      bsp_pkg::SD_MUL_B: state_next = bsp_pkg::SD_CMP;
      bsp_pkg::SD_CMP: begin
        done_next  = 1'b1;
        side_next  = ($signed(prod_a) >= $signed(prod_b));
        state_next = bsp_pkg::SD_IDLE;
      end
      default: state_next = bsp_pkg::SD_IDLE;
    endcase
  end

  // State and handshake register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bsp_pkg::SD_IDLE;
      res.done <= 1'b0;
      res.side <= 1'b0;
    end else begin
      state    <= state_next;
      res.done <= done_next;
      res.side <= side_next;
    end
  end

  // Datapath registers: keep the relative position and the truncated fixed products
  always_ff @(posedge clk) begin
    if (load_rel) begin
      rx <= rx_c;
      ry <= ry_c;
    end
    if (state == bsp_pkg::SD_MUL_A) begin
      prod_a <= mul_a[PW-1:HW];
    end
    if (state == bsp_pkg::SD_MUL_B) begin
      prod_b <= mul_b[PW-1:HW];
    end
  end

endmodule

@@ hw/rtl/bsp_point_location_walk.sv @@
// Top level of the partition point location walk.
`timescale 1ns / 1ps

// Point location in a binary space partition tree held in one node RAM.
// A write transaction (action 0) stores one node and gives no result;
// slots at or above MAX_NODES are dropped. A query transaction (action 1)
// walks from node node_count-1 (node_count clamped to MAX_NODES) to a leaf
// and gives one result. Each tree level costs one RAM read plus a side
// test, settled at once by a zero direction or a sign difference, else by
// the two 32x16 fixed products (one multiply per cycle) and a compare.
// With no nodes a query gives its result without reading the RAM.
// The next transaction is taken while a finished result waits on the output.
// walk_fault flags a walk longer than the node count, a node child outside
// the node count or a leaf child at or above MAX_LEAVES; leaf_index is 0 then.
// Reading a node never written since reset returns undefined contents.
module bsp_point_location_walk #(
  parameter int MAX_NODES  = bsp_pkg::DEF_MAX_NODES,
  parameter int MAX_LEAVES = bsp_pkg::DEF_MAX_LEAVES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bsp_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [bsp_pkg::SLOT_W-1:0]   node_slot,
  input  logic signed [bsp_pkg::COORD_W-1:0] coord_x,
  input  logic signed [bsp_pkg::COORD_W-1:0] coord_y,
  input  logic signed [bsp_pkg::COORD_W-1:0] dir_x,
  input  logic signed [bsp_pkg::COORD_W-1:0] dir_y,
  input  logic [bsp_pkg::CHILD_W-1:0]  front_child,
  input  logic                         front_is_leaf,
  input  logic [bsp_pkg::CHILD_W-1:0]  back_child,
  input  logic                         back_is_leaf,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bsp_pkg::LEAF_W-1:0]   leaf_index,
  output logic                         walk_fault
);

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int NODE_W  = $bits(bsp_pkg::node_t);

  bsp_pkg::walk_state_t state, state_next;
  bsp_pkg::node_t       wr_node, rd_node;
  bsp_pkg::side_req_t   side_req;
  bsp_pkg::side_res_t   side_res;

  logic [bsp_pkg::COUNT_W-1:0] node_count;
  logic [CNT_W-1:0]            count_used;
  logic [CNT_W-1:0]            visits, visits_next, visits_inc;
  logic [NODE_AW-1:0]          rd_addr, rd_addr_next;
  logic [bsp_pkg::COORD_W-1:0] px, py;
  logic [bsp_pkg::LEAF_W-1:0]  res_leaf, res_leaf_next;
  logic                        res_fault, res_fault_next;
  logic                        in_take, wr_en, fin_go;
  logic [bsp_pkg::CHILD_W-1:0] sel_child;
  logic                        sel_leaf;

  // Configuration: always ready; to be written only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  // Clamp the node count to the table size
  always_comb begin
    if (32'(node_count) > 32'(MAX_NODES)) begin
      count_used = CNT_W'(MAX_NODES);
    end else begin
      count_used = CNT_W'(node_count);
    end
  end

  assign in_ready = (state == bsp_pkg::W_IDLE);
  assign in_take  = in_valid && in_ready;
  assign fin_go   = (state == bsp_pkg::W_FINISH) && (!out_valid || out_ready);

  // Node write from a write transaction
  assign wr_en = in_take && (action == bsp_pkg::ACT_WRITE) &&
                 (32'(node_slot) < 32'(MAX_NODES));
  always_comb begin
    wr_node.org_x         = coord_x;
    wr_node.org_y         = coord_y;
    wr_node.dir_x         = dir_x;
    wr_node.dir_y         = dir_y;
    wr_node.front_child   = front_child;
    wr_node.front_is_leaf = front_is_leaf;
    wr_node.back_child    = back_child;
    wr_node.back_is_leaf  = back_is_leaf;
  end

  bsp_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (NODE_AW'(node_slot)),
    .wr_data (wr_node),
    .rd_en   (state == bsp_pkg::W_FETCH),
    .rd_addr (rd_addr),
    .rd_data (rd_node)
  );

  // Side test on the node just read
  always_comb begin
    side_req.start = (state == bsp_pkg::W_START);
    side_req.px    = px;
    side_req.py    = py;
    side_req.org_x = rd_node.org_x;
    side_req.org_y = rd_node.org_y;
    side_req.dir_x = rd_node.dir_x;
    side_req.dir_y = rd_node.dir_y;
  end

  bsp_side u_side (
    .clk (clk),
    .rst (rst),
    .req (side_req),
    .res (side_res)
  );

  assign sel_child  = side_res.side ? rd_node.back_child : rd_node.front_child;
  assign sel_leaf   = side_res.side ? rd_node.back_is_leaf : rd_node.front_is_leaf;
  assign visits_inc = visits + CNT_W'(1);

  // Walk sequencer
  always_comb begin
    state_next     = state;
    visits_next    = visits;
    rd_addr_next   = rd_addr;
    res_leaf_next  = res_leaf;
    res_fault_next = res_fault;
    case (state)
      bsp_pkg::W_IDLE: begin
        if (in_take && (action == bsp_pkg::ACT_QUERY)) begin
          res_leaf_next  = '0;
          res_fault_next = 1'b0;
          visits_next    = '0;
          rd_addr_next   = NODE_AW'(count_used - CNT_W'(1));
          if (count_used == '0) begin
            state_next = bsp_pkg::W_FINISH;
          end else begin
            state_next = bsp_pkg::W_FETCH;
          end
        end
      end
      bsp_pkg::W_FETCH: state_next = bsp_pkg::W_START;
      bsp_pkg::W_START: state_next = bsp_pkg::W_WAIT;
      bsp_pkg::W_WAIT: begin
        if (side_res.done) begin
          state_next = bsp_pkg::W_FINISH;
          if (sel_leaf) begin
            if (32'(sel_child) >= 32'(MAX_LEAVES)) begin
              res_fault_next = 1'b1;
            end else begin
              res_leaf_next = sel_child;
            end
          end else if (32'(sel_child) >= 32'(count_used)) begin
            res_fault_next = 1'b1;
          end else if (visits_inc >= count_used) begin
            res_fault_next = 1'b1;
          end else begin
            visits_next  = visits_inc;
            rd_addr_next = NODE_AW'(sel_child);
            state_next   = bsp_pkg::W_FETCH;
          end
        end
      end
      bsp_pkg::W_FINISH: begin
        if (fin_go) begin
          state_next = bsp_pkg::W_IDLE;
        end
      end
      default: state_next = bsp_pkg::W_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsp_pkg::W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk payload registers
  always_ff @(posedge clk) begin
    visits    <= visits_next;
    rd_addr   <= rd_addr_next;
    res_leaf  <= res_leaf_next;
    res_fault <= res_fault_next;
    if (in_take) begin
      px <= coord_x;
      py <= coord_y;
    end
  end

  // Output register: hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      leaf_index <= res_leaf;
      walk_fault <= res_fault;
    end
  end

endmodule

@@ hw/rtl/bsp_chk.sv @@
// Port-level checker for the partition walk, bound to the top level.
`timescale 1ns / 1ps
`include "bsp_point_location_walk_macros.svh"

module bsp_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bsp_pkg::LEAF_W-1:0]  leaf_index,
  input logic                        walk_fault
);

  // A stalled result holds its value
  `BSP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(leaf_index) && $stable(walk_fault), "result changed while stalled")

  // A failed walk reports leaf zero
  `BSP_ASSERT_NOW(a_fault_leaf, clk, rst, out_valid && walk_fault, leaf_index == '0, "fault with nonzero leaf")

  // A query transaction, once taken, closes the input
  `BSP_ASSERT_NEXT(a_query_busy, clk, rst, in_valid && in_ready && (action == bsp_pkg::ACT_QUERY), !in_ready, "input open during a walk")

  // A write transaction on an empty output produces no result
  `BSP_ASSERT_NEXT(a_write_quiet, clk, rst, in_valid && in_ready && (action == bsp_pkg::ACT_WRITE) && !out_valid, !out_valid, "result from a node write")

  // Reset empties the output
  `BSP_ASSERT_NEXT_ALWAYS(a_reset_out, clk, rst, !out_valid, "output valid after reset")

endmodule

bind bsp_point_location_walk bsp_chk u_bsp_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .action     (action),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .leaf_index (leaf_index),
  .walk_fault (walk_fault)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the partition tree point location walk.
`timescale 1ns / 1ps

// One input transaction as the sender presents it
typedef struct {
  logic                                act;
  logic        [bsp_pkg::SLOT_W-1:0]   slot;
  logic signed [bsp_pkg::COORD_W-1:0]  cx;
  logic signed [bsp_pkg::COORD_W-1:0]  cy;
  logic signed [bsp_pkg::COORD_W-1:0]  dx;
  logic signed [bsp_pkg::COORD_W-1:0]  dy;
  logic        [bsp_pkg::CHILD_W-1:0]  fc;
  logic                                fl;
  logic        [bsp_pkg::CHILD_W-1:0]  bc;
  logic                                bl;
} walk_req_t;

// Node table mirror, leaf predictor and result checker
class leaf_scoreboard;
  bsp_pkg::node_t               node_mem [bsp_pkg::DEF_MAX_NODES];
  logic [bsp_pkg::COUNT_W-1:0]  count_reg;
  logic [bsp_pkg::LEAF_W:0]     pending_leaves [$];  // {fault, leaf}
  int mismatches;
  int checked;
  int writes;
  int queries;
  int faults;
  int settings;

  function new();
    count_reg  = '0;
    mismatches = 0;
    checked    = 0;
    writes     = 0;
    queries    = 0;
    faults     = 0;
    settings   = 0;
  endfunction

  function void set_count(logic [bsp_pkg::COUNT_W-1:0] v);
    count_reg = v;
    settings++;
  endfunction

  // Low 32 bits of the 64-bit product shifted right by 16
  function int fix_mul_q16(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return int'(p >>> 16);
  endfunction

  // Side of the partition line the point falls on: 1 takes the back child
  function bit side_of_node(int x, int y, bsp_pkg::node_t n);
    int ox, oy, dx, dy, rx, ry;
    ox = n.org_x;
    oy = n.org_y;
    dx = n.dir_x;
    dy = n.dir_y;
    if (dx == 0) return (x <= ox) ? (dy > 0) : (dy < 0);
    if (dy == 0) return (y <= oy) ? (dx < 0) : (dx > 0);
    rx = x - ox;
    ry = y - oy;
    // differing signs settle the side without a multiply
    if ((dy ^ dx ^ rx ^ ry) < 0) return (dy ^ rx) < 0;
    return fix_mul_q16(ry, dx >>> 16) >= fix_mul_q16(dy >>> 16, rx);
  endfunction

  // Walk from the root to a leaf; a failed walk gives fault and leaf 0
  function logic [bsp_pkg::LEAF_W:0] locate_leaf(int x, int y);
    int unsigned used, cur, steps;
    logic [bsp_pkg::CHILD_W-1:0] child;
    logic lf;
    bsp_pkg::node_t n;
    used = (32'(count_reg) > bsp_pkg::DEF_MAX_NODES) ? bsp_pkg::DEF_MAX_NODES
                                                      : 32'(count_reg);
    if (used == 0) return '0;
    cur = used - 1;
    for (steps = 0; steps < used; steps++) begin
      n = node_mem[cur];
      if (side_of_node(x, y, n)) begin
        child = n.back_child;
        lf    = n.back_is_leaf;
      end else begin
        child = n.front_child;
        lf    = n.front_is_leaf;
      end
      if (lf) begin
        if (int'(child) >= bsp_pkg::DEF_MAX_LEAVES) return {1'b1, 13'd0};
        return {1'b0, child};
      end
      if (32'(child) >= used) return {1'b1, 13'd0};
      cur = 32'(child);
    end
    return {1'b1, 13'd0};
  endfunction

  // Record an accepted transaction: store a node or queue the expected leaf
  function void note_input(walk_req_t r);
    logic [bsp_pkg::LEAF_W:0] res;
    if (r.act == bsp_pkg::ACT_WRITE) begin
      node_mem[r.slot].org_x         = r.cx;
      node_mem[r.slot].org_y         = r.cy;
      node_mem[r.slot].dir_x         = r.dx;
      node_mem[r.slot].dir_y         = r.dy;
      node_mem[r.slot].front_child   = r.fc;
      node_mem[r.slot].front_is_leaf = r.fl;
      node_mem[r.slot].back_child    = r.bc;
      node_mem[r.slot].back_is_leaf  = r.bl;
      writes++;
    end else begin
      res = locate_leaf(r.cx, r.cy);
      if (res[bsp_pkg::LEAF_W]) faults++;
      pending_leaves.push_back(res);
      queries++;
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(logic [bsp_pkg::LEAF_W-1:0] leaf, logic fault);
    logic [bsp_pkg::LEAF_W:0] want;
    checked++;
    if (pending_leaves.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result %0d: leaf %0d fault %0b with nothing pending",
                 checked, leaf, fault);
      return;
    end
    want = pending_leaves.pop_front();
    if (want[bsp_pkg::LEAF_W-1:0] !== leaf || want[bsp_pkg::LEAF_W] !== fault) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d: expected leaf %0d fault %0b, %s %0d fault %0b",
                 checked, want[bsp_pkg::LEAF_W-1:0], want[bsp_pkg::LEAF_W],
                 "got leaf", leaf, fault);
    end
  endfunction
endclass

module testbench;

  localparam int          ITEMS        = 950;
  localparam int          CYCLE_LIMIT  = 6000000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CHOKE_PHASE  = 7;
  localparam logic [31:0] MAXC         = 32'h7fffffff;
  localparam logic [31:0] MINC         = 32'h80000000;
  localparam logic [31:0] ONE          = 32'h00010000;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [bsp_pkg::COUNT_W-1:0]           cfg_data;
  logic                                  in_valid;
  logic                                  in_ready;
  logic                                  action;
  logic [bsp_pkg::SLOT_W-1:0]            node_slot;
  logic signed [bsp_pkg::COORD_W-1:0]    coord_x;
  logic signed [bsp_pkg::COORD_W-1:0]    coord_y;
  logic signed [bsp_pkg::COORD_W-1:0]    dir_x;
  logic signed [bsp_pkg::COORD_W-1:0]    dir_y;
  logic [bsp_pkg::CHILD_W-1:0]           front_child;
  logic                                  front_is_leaf;
  logic [bsp_pkg::CHILD_W-1:0]           back_child;
  logic                                  back_is_leaf;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [bsp_pkg::LEAF_W-1:0]            leaf_index;
  logic                                  walk_fault;

  leaf_scoreboard board;
  bit  slot_used [bsp_pkg::DEF_MAX_NODES];
  int  items_sent = 0;
  int  phase_no   = 0;
  int  cur_span   = 0;
  bit  steady     = 1'b0;
  bit  choke_req  = 1'b0;
  bit  choke_done = 1'b0;
  int  hold_left  = 0;
  int  cycle_count = 0;

  bsp_point_location_walk dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .node_slot     (node_slot),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .front_child   (front_child),
    .front_is_leaf (front_is_leaf),
    .back_child    (back_child),
    .back_is_leaf  (back_is_leaf),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .leaf_index    (leaf_index),
    .walk_fault    (walk_fault)
  );

  always #4 clk = ~clk;

  // Receiver: random backpressure, one long hold-off, steady stretch
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (choke_req && !choke_done) begin
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      choke_done <= 1'b1;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(leaf_index, walk_fault);
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [31:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      case ($urandom_range(0, 4))
        0: return MINC;
        1: return MAXC;
        2: return 32'h0;
        3: return 32'hffffffff;
        default: return ONE;
      endcase
    end
    if (sel < 50) return $urandom_range(0, 32'h01ffffff) - 32'h01000000;
    return $urandom();
  endfunction

  function automatic logic [31:0] rand_dir();
    if ($urandom_range(0, 99) < 15) return 32'h0;
    return rand_coord();
  endfunction

  // Random written slot below lim, else the slot written at start
  function automatic int pick_used(int lim);
    int s;
    for (int t = 0; t < 8; t++) begin
      s = $urandom_range(0, lim - 1);
      if (slot_used[s]) return s;
    end
    return bsp_pkg::DEF_MAX_NODES - 1;
  endfunction

  // Child link: a leaf, a written node, or a node index past the count
  function automatic void pick_child(input int lim,
                                     output logic [bsp_pkg::CHILD_W-1:0] c,
                                     output logic lf);
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 45 || lim == 0) begin
      lf = 1'b1;
      if (r < 4) c = '0;
      else if (r < 8) c = '1;
      else c = bsp_pkg::CHILD_W'($urandom_range(0, bsp_pkg::DEF_MAX_LEAVES - 1));
    end else if (r < 90) begin
      lf = 1'b0;
      c  = bsp_pkg::CHILD_W'(pick_used(lim));
    end else begin
      lf = 1'b0;
      v  = $urandom_range(lim, 8191);
      // keep never-written slots unreachable under any later count
      if (v < bsp_pkg::DEF_MAX_NODES && !slot_used[v]) v = v + bsp_pkg::DEF_MAX_NODES;
      c = bsp_pkg::CHILD_W'(v);
    end
  endfunction

  function automatic walk_req_t mk_node(int slot, logic [31:0] ox, logic [31:0] oy,
                                        logic [31:0] dx, logic [31:0] dy,
                                        int fc, logic fl, int bc, logic bl);
    walk_req_t r;
    r.act  = bsp_pkg::ACT_WRITE;
    r.slot = bsp_pkg::SLOT_W'(slot);
    r.cx   = ox;
    r.cy   = oy;
    r.dx   = dx;
    r.dy   = dy;
    r.fc   = bsp_pkg::CHILD_W'(fc);
    r.fl   = fl;
    r.bc   = bsp_pkg::CHILD_W'(bc);
    r.bl   = bl;
    return r;
  endfunction

  // Query with random content in the fields it does not use
  function automatic walk_req_t mk_point(logic [31:0] x, logic [31:0] y);
    walk_req_t r;
    r      = mk_node($urandom_range(0, bsp_pkg::DEF_MAX_NODES - 1), x, y,
                     $urandom(), $urandom(),
                     $urandom_range(0, 8191), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 8191), 1'($urandom_range(0, 1)));
    r.act  = bsp_pkg::ACT_QUERY;
    return r;
  endfunction

  function automatic walk_req_t rand_node(int slot, int lim);
    walk_req_t r;
    r = mk_node(slot, rand_coord(), rand_coord(), rand_dir(), rand_dir(), 0, 0, 0, 0);
    pick_child(lim, r.fc, r.fl);
    pick_child(lim, r.bc, r.bl);
    return r;
  endfunction

  // Random point, sometimes on a node origin line
  function automatic walk_req_t rand_point();
    walk_req_t r;
    int s;
    r = mk_point(rand_coord(), rand_coord());
    if (cur_span > 0 && $urandom_range(0, 9) == 0) begin
      s = pick_used(cur_span);
      if ($urandom_range(0, 1)) r.cx = board.node_mem[s].org_x;
      else r.cy = board.node_mem[s].org_y;
    end
    return r;
  endfunction

  // Offer one transaction, idling at random first, and hold until taken
  task automatic push_item(input walk_req_t r);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if (r.act == bsp_pkg::ACT_WRITE) slot_used[r.slot] = 1'b1;
    in_valid      <= 1'b1;
    action        <= r.act;
    node_slot     <= r.slot;
    coord_x       <= r.cx;
    coord_y       <= r.cy;
    dir_x         <= r.dx;
    dir_y         <= r.dy;
    front_child   <= r.fc;
    front_is_leaf <= r.fl;
    back_child    <= r.bc;
    back_is_leaf  <= r.bl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(r);
    items_sent++;
  endtask

  // Drop valid and let every pending result drain
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.pending_leaves.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(input logic [bsp_pkg::COUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_count(v);
    cfg_valid <= 1'b0;
    cur_span = (32'(v) > bsp_pkg::DEF_MAX_NODES) ? bsp_pkg::DEF_MAX_NODES : 32'(v);
  endtask

  task automatic query_at(input logic [31:0] x, input logic [31:0] y);
    push_item(mk_point(x, y));
  endtask

  // One count setting: optional fresh tree, then mostly queries
  task automatic run_phase(input logic [bsp_pkg::COUNT_W-1:0] cnt, input int n_items,
                           input bit rebuild);
    int k;
    int i;
    int slot;
    wait_quiet();
    write_count(cnt);
    if (rebuild) begin
      for (k = 0; k < cur_span; k++) push_item(rand_node(k, k));
    end
    for (i = 0; i < n_items; i++) begin
      if (phase_no == CHOKE_PHASE && i == 2) choke_req = 1'b1;
      if (cur_span > 0 && !slot_used[cur_span - 1]) begin
        push_item(rand_node(cur_span - 1, cur_span));
      end else if ($urandom_range(0, 99) < 78) begin
        push_item(rand_point());
      end else begin
        if (cur_span == 0 || $urandom_range(0, 99) < 25)
          slot = $urandom_range(0, bsp_pkg::DEF_MAX_NODES - 1);
        else
          slot = $urandom_range(0, cur_span - 1);
        push_item(rand_node(slot, (cur_span == 0) ? bsp_pkg::DEF_MAX_NODES : cur_span));
      end
    end
  endtask

  initial begin
    logic [bsp_pkg::COUNT_W-1:0] cnt;
    board         = new();
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    action        = bsp_pkg::ACT_WRITE;
    node_slot     = '0;
    coord_x       = '0;
    coord_y       = '0;
    dir_x         = '0;
    dir_y         = '0;
    front_child   = '0;
    front_is_leaf = 1'b0;
    back_child    = '0;
    back_is_leaf  = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty tree after reset answers leaf 0
    query_at(32'h0, 32'h0);
    // vertical line, horizontal line, general line, self loop, top slot
    push_item(mk_node(0, 32'h0, 32'h0, 32'h0, ONE, 5, 1'b1, 6, 1'b1));
    push_item(mk_node(1, MAXC, MINC, -ONE, 32'h0, 13'h1fff, 1'b1, 0, 1'b0));
    push_item(mk_node(2, ONE, -ONE, MAXC, MINC, 1, 1'b0, 13'h0aaa, 1'b1));
    push_item(mk_node(3, 32'h0, 32'h0, 32'h0, ONE, 3, 1'b0, 13'h1fff, 1'b0));
    push_item(mk_node(bsp_pkg::DEF_MAX_NODES - 1, MINC, MAXC, 32'h12345678, 32'hfedcba98,
                      2, 1'b0, 3, 1'b0));
    // single node: on the line and either side of it
    wait_quiet();
    write_count(1);
    query_at(32'h0, 32'h0);
    query_at(32'h1, 32'h0);
    query_at(MINC, MAXC);
    // general line at the root, extremes and the origin itself
    wait_quiet();
    write_count(3);
    query_at(32'h0, 32'h0);
    query_at(MAXC, MAXC);
    query_at(MINC, MINC);
    query_at(ONE, -ONE);
    query_at(32'h00030000, 32'h00050000);
    query_at(32'hfffd0000, 32'h00020000);
    // self loop walks too long; the other side hits a child past the count
    wait_quiet();
    write_count(4);
    query_at(32'hffffffff, 32'h0);
    query_at(32'h1, 32'h0);
    // count above the table size clamps to the full table
    wait_quiet();
    write_count(13'h1fff);
    query_at(MAXC, 32'h0);
    query_at(MINC, MINC);
    query_at(32'h00100000, 32'hfff00000);

    // Random phases until the item budget is spent
    while (items_sent < ITEMS) begin
      steady = (phase_no >= 12 && phase_no < 16);
      if (phase_no == 3) begin
        run_phase(0, 6, 1'b0);
      end else if (phase_no == 4) begin
        run_phase(1, 20, 1'b1);
      end else if (phase_no == 5) begin
        run_phase(bsp_pkg::COUNT_W'(bsp_pkg::DEF_MAX_NODES), 4, 1'b0);
      end else if (phase_no == 9) begin
        run_phase(13'h1fff, 4, 1'b0);
      end else begin
        if ($urandom_range(0, 9) == 0) cnt = bsp_pkg::COUNT_W'($urandom_range(25, 160));
        else cnt = bsp_pkg::COUNT_W'($urandom_range(2, 24));
        run_phase(cnt, (phase_no == CHOKE_PHASE) ? 40 : $urandom_range(16, 32), cnt <= 48);
      end
      phase_no++;
    end
    steady = 1'b0;

    // Drain and settle
    in_valid <= 1'b0;
    while (board.pending_leaves.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d node writes and %0d point queries (%0d faulted walks)",
             board.writes, board.queries, board.faults);
    $display("over %0d node count settings; %0d results checked, %0d mismatches",
             board.settings, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_leaves.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
